// ===== hw/rtl/lkv_pkg.sv =====
package lkv_pkg;

  // Number of entry slots in the store.
  localparam int unsigned ENTRIES = 16;

  // Slot index, age rank and fill count widths.
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  // Field widths of the item and of the capacity register.
  localparam int unsigned KeyW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW = 5;

  // Common width for comparing the capacity register against the entry count.
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  // Item mode codes.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP,
    ST_UPDATE,
    ST_EVICT,
    ST_INSERT
  } lkv_state_e;

  typedef enum logic [1:0] {
    RANK_NONE,
    RANK_TOUCH,
    RANK_EVICT,
    RANK_INSERT
  } lkv_rank_op_e;

  // One command to the recency tracker.
  typedef struct packed {
    lkv_rank_op_e       op;
    logic [IdxW-1:0]    idx;     // entry to touch or to fill
    logic [RankW-1:0]   ref_rank; // age rank of the touched entry
    logic [CntW-1:0]    cap;     // effective capacity for eviction
  } lkv_rank_cmd_t;

  // One stored key-value pair.
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
  } lkv_entry_t;

endpackage

// ===== hw/rtl/lkv_kv_mem.sv =====
module lkv_kv_mem
  import lkv_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  lkv_entry_t        wr_entry_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output lkv_entry_t        rd_entry_o
);

  lkv_entry_t mem_q [ENTRIES];
  lkv_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

// ===== hw/rtl/lkv_rank.sv =====
module lkv_rank
  import lkv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lkv_rank_cmd_t     cmd_i,
  input  logic [IdxW-1:0]   look_idx_i,
  output logic              look_valid_o,
  output logic [RankW-1:0]  look_rank_o,
  output logic [CntW-1:0]   used_o
);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RankW-1:0]   rank_q [ENTRIES];
  logic [RankW-1:0]   rank_d [ENTRIES];
  logic [CntW-1:0]    used_q, used_d;
  logic [CntW-1:0]    cap_m1;

  assign cap_m1 = cmd_i.cap - CntW'(1);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    used_d  = used_q;
    for (int i = 0; i < ENTRIES; i++) begin
      case (cmd_i.op)
        RANK_TOUCH: begin
          if (IdxW'(i) == cmd_i.idx) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < cmd_i.ref_rank)) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
        RANK_EVICT: begin
          if (valid_q[i] && (CntW'(rank_q[i]) >= cap_m1)) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end
        end
        RANK_INSERT: begin
          if (IdxW'(i) == cmd_i.idx) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    case (cmd_i.op)
      RANK_EVICT:  used_d = cap_m1;
      RANK_INSERT: used_d = used_q + CntW'(1);
      default:     used_d = used_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      rank_q  <= rank_d;
    end
  end

  assign look_valid_o = valid_q[look_idx_i];
  assign look_rank_o  = rank_q[look_idx_i];
  assign used_o       = used_q;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_stall_o  mode_i, key_i, value_i
// out      source     out_valid_o / out_stall_i hit_o, data_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (capacity_in_use)
//
// One item is worked on at a time; a new item is not accepted until the last one
// is through. A put on an absent key passes through an extra eviction step when
// the store is full. Every item waits for the whole scan of the key memory,
// one entry read per cycle.
// Reset clears the valid bits, age ranks and fill count at once; the key
// memory needs no clearing pass. A result waits in the output register while
// the next item is accepted; only a second result waits for out_stall_i.
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [DataW-1:0]  value_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic [DataW-1:0]  data_o,
  // Capacity register write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CapW-1:0]   cfg_data_i
);

  lkv_state_e state_q, state_d;

  // Latched request.
  logic              mode_q;
  logic [KeyW-1:0]   key_q;
  logic [DataW-1:0]  value_q;

  // Capacity register and its clamped value.
  logic [CapW-1:0]   cap_cfg_q;
  logic [CmpW-1:0]   cap_ext;
  logic [CmpW-1:0]   cap_clamp;
  logic [CntW-1:0]   cap_eff;
  logic [CntW-1:0]   cap_m1;

  // Scan pointer and the compare stage behind the memory read.
  logic [CntW-1:0]   scan_q, scan_d;
  logic              chk_q;
  logic [IdxW-1:0]   chk_idx_q;
  logic              scan_issue;
  logic              scan_done;

  // What the scan has found so far.
  logic              hit_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic [RankW-1:0]  hit_rank_q;
  logic [DataW-1:0]  hit_data_q;
  logic              free_found_q;
  logic [IdxW-1:0]   free_idx_q;
  logic              old_found_q;
  logic [IdxW-1:0]   old_idx_q;
  logic [IdxW-1:0]   slot_q;

  logic              need_evict;

  // Memory and recency tracker hookup.
  logic              mem_wr_en;
  logic [IdxW-1:0]   mem_wr_addr;
  lkv_entry_t        mem_wr_entry;
  lkv_entry_t        mem_rd_entry;
  lkv_rank_cmd_t     rank_cmd;
  logic              look_valid;
  logic [RankW-1:0]  look_rank;
  logic [CntW-1:0]   used;

  // Output register.
  logic              out_valid_q;
  logic              out_hit_q;
  logic [DataW-1:0]  out_data_q;
  logic              out_free;
  logic              out_load;

  logic              in_accept;
  logic              chk_match;

  assign in_accept = in_valid_i && !in_stall_o;

  // The capacity is held between one and ENTRIES.
  assign cap_ext = CmpW'(cap_cfg_q);
  always_comb begin
    if (cap_ext == '0) begin
      cap_clamp = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      cap_clamp = CmpW'(ENTRIES);
    end else begin
      cap_clamp = cap_ext;
    end
  end
  assign cap_eff = CntW'(cap_clamp);
  assign cap_m1  = cap_eff - CntW'(1);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= CapW'(ENTRIES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_cfg_q <= cfg_data_i;
    end
  end

  // Scan: one read issued per cycle, compared in the next cycle.
  assign scan_issue = (state_q == ST_SCAN) && (scan_q != CntW'(ENTRIES));
  assign scan_done  = (state_q == ST_SCAN) && (scan_q == CntW'(ENTRIES)) && !chk_q;
  assign scan_d     = (state_q == ST_SCAN) ? (scan_issue ? scan_q + CntW'(1) : scan_q) : '0;
  assign chk_match  = chk_q && look_valid && (mem_rd_entry.key == key_q);

  assign need_evict = (used >= cap_eff);

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (mode_q == MODE_GET) begin
            state_d = ST_RESP;
          end else if (hit_q) begin
            state_d = ST_UPDATE;
          end else if (need_evict) begin
            state_d = ST_EVICT;
          end else begin
            state_d = ST_INSERT;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      ST_EVICT:  state_d = ST_INSERT;
      ST_INSERT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs: memory write, tracker command, result load.
  always_comb begin
    in_stall_o        = 1'b1;
    mem_wr_en         = 1'b0;
    mem_wr_addr       = hit_idx_q;
    rank_cmd.op       = RANK_NONE;
    rank_cmd.idx      = hit_idx_q;
    rank_cmd.ref_rank = hit_rank_q;
    rank_cmd.cap      = cap_eff;
    out_load          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_RESP: begin
        out_load = out_free;
        if (out_free && hit_q) begin
          rank_cmd.op = RANK_TOUCH;
        end
      end
      ST_UPDATE: begin
        mem_wr_en   = 1'b1;
        rank_cmd.op = RANK_TOUCH;
      end
      ST_EVICT: begin
        rank_cmd.op = RANK_EVICT;
      end
      ST_INSERT: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = slot_q;
        rank_cmd.op  = RANK_INSERT;
        rank_cmd.idx = slot_q;
      end
      default: begin
      end
    endcase
  end

  assign mem_wr_entry = {key_q, value_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      chk_q   <= scan_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request latch, scan trackers, chosen slot and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q       <= mode_i;
      key_q        <= key_i;
      value_q      <= value_i;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
    end
    if (scan_issue) begin
      chk_idx_q <= scan_q[IdxW-1:0];
    end
    if (chk_match) begin
      hit_q      <= 1'b1;
      hit_idx_q  <= chk_idx_q;
      hit_rank_q <= look_rank;
      hit_data_q <= mem_rd_entry.data;
    end
    if (chk_q && !look_valid && !free_found_q) begin
      free_found_q <= 1'b1;
      free_idx_q   <= chk_idx_q;
    end
    if (chk_q && look_valid && !old_found_q && (CntW'(look_rank) >= cap_m1)) begin
      old_found_q <= 1'b1;
      old_idx_q   <= chk_idx_q;
    end
    // After an eviction the lowest free slot is the lower of the first free
    // slot and the first evicted one.
    if (scan_done) begin
      if (need_evict && old_found_q && (!free_found_q || (old_idx_q < free_idx_q))) begin
        slot_q <= old_idx_q;
      end else begin
        slot_q <= free_idx_q;
      end
    end
    if (out_load) begin
      out_hit_q  <= hit_q;
      out_data_q <= hit_q ? hit_data_q : '0;
    end
  end

  lkv_kv_mem u_kv_mem (
    .clk_i      (clk_i),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (mem_wr_addr),
    .wr_entry_i (mem_wr_entry),
    .rd_en_i    (scan_issue),
    .rd_addr_i  (scan_q[IdxW-1:0]),
    .rd_entry_o (mem_rd_entry)
  );

  lkv_rank u_rank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (rank_cmd),
    .look_idx_i   (chk_idx_q),
    .look_valid_o (look_valid),
    .look_rank_o  (look_rank),
    .used_o       (used)
  );

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign data_o      = out_data_q;

endmodule

// ===== verif/lru_cache_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, result and capacity channels of the cache, keeps its own
// copy of the store and checks every accepted result against the oldest answer.
module lru_cache_checker
  import lkv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             mode_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [DataW-1:0] value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             hit_i,
  input  logic [DataW-1:0] data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CapW-1:0]  cfg_data_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               lookups_o,
  output int               hits_o
);

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] data;
  } lookup_answer_t;

  lookup_answer_t answer_q[$];

  logic [CapW-1:0]  cap_reg;
  logic             slot_valid[ENTRIES];
  logic [KeyW-1:0]  slot_key[ENTRIES];
  logic [DataW-1:0] slot_data[ENTRIES];
  logic [RankW-1:0] slot_rank[ENTRIES];
  logic [CntW-1:0]  fill_count;

  initial begin
    mismatches_o = 0;
    pending_o = 0;
    lookups_o = 0;
    hits_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("%0t: %s: got %h, wanted %h", $realtime, what, got, want);
    mismatches_o++;
  endtask

  // The capacity register is clamped to 1 .. ENTRIES.
  function automatic int usable_slots();
    if (cap_reg == '0) return 1;
    if (cap_reg > ENTRIES) return ENTRIES;
    return int'(cap_reg);
  endfunction

  function automatic int find_slot(input logic [KeyW-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void make_recent(input int idx);
    logic [RankW-1:0] r;
    r = slot_rank[idx];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[idx] = '0;
  endfunction

  // A full store drops every entry at or beyond the oldest allowed rank, which
  // also trims the surplus left behind when the capacity was lowered.
  function automatic void store_new(input logic [KeyW-1:0] k, input logic [DataW-1:0] v);
    int c;
    int free_slot;
    c = usable_slots();
    free_slot = -1;
    if (int'(fill_count) >= c) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && int'(slot_rank[i]) >= c - 1) begin
          slot_valid[i] = 1'b0;
          slot_rank[i] = '0;
        end
      end
      fill_count = CntW'(c - 1);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i]) slot_rank[i]++;
      else if (free_slot < 0) free_slot = i;
    end
    if (free_slot >= 0) begin
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = k;
      slot_data[free_slot] = v;
      slot_rank[free_slot] = '0;
      fill_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_answer_t want;
    int idx;
    if (!rst_ni) begin
      cap_reg = CapW'(ENTRIES);
      fill_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i] = '0;
        slot_data[i] = '0;
        slot_rank[i] = '0;
      end
      answer_q.delete();
    end else begin
      // Results leave before a new request enters, so a result seen at the
      // same edge as an accepted get always belongs to an older request.
      if (out_valid_i && !out_stall_i) begin
        lookups_o++;
        if (hit_i === 1'b1) hits_o++;
        if (answer_q.size() == 0) begin
          report_mismatch("result with no lookup waiting", data_i, '0);
        end else begin
          want = answer_q.pop_front();
          if (hit_i !== want.hit) report_mismatch("hit flag", DataW'(hit_i), DataW'(want.hit));
          if (data_i !== want.data) report_mismatch("data", data_i, want.data);
        end
      end
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        idx = find_slot(key_i);
        if (mode_i == MODE_GET) begin
          want = '0;
          if (idx >= 0) begin
            want.hit = 1'b1;
            want.data = slot_data[idx];
            make_recent(idx);
          end
          answer_q.push_back(want);
        end else if (idx >= 0) begin
          slot_data[idx] = value_i;
          make_recent(idx);
        end else begin
          store_new(key_i, value_i);
        end
      end
    end
    pending_o = answer_q.size();
  end

endmodule

// ===== verif/tb_lru_key_value_cache.sv =====
`timescale 1ns / 100ps

// Top of the cache testbench. It drives requests and capacity writes into the
// block, stalls the result channel at random, and leaves all prediction and
// comparison to the checker instantiated beside the block.
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int POOL_SIZE = 24;
  // A put gives no result, so after the last answer the block may still be
  // busy for one full request.
  localparam int SETTLE_CYCLES = ENTRIES + 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             mode;
  logic [KeyW-1:0]  key;
  logic [DataW-1:0] value;
  logic             out_valid;
  logic             out_stall;
  logic             hit;
  logic [DataW-1:0] data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CapW-1:0]  cfg_data;

  int mismatches;
  int pending;
  int lookups;
  int hits;

  // Driver knobs and counters; quiet_phase is shared with the result stall driver.
  bit quiet_phase;
  int stall_hold;
  int requests_sent;
  int capacity_writes;
  logic [KeyW-1:0] key_pool[POOL_SIZE];

  always #4 clk = ~clk;

  lru_key_value_cache dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .key_i       (key),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .hit_o       (hit),
    .data_o      (data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  lru_cache_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .key_i        (key),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hit_i        (hit),
    .data_i       (data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .lookups_o    (lookups),
    .hits_o       (hits)
  );

  // Mostly back-to-back requests, some short gaps and now and then a long one.
  // Quiet phases run with no gaps at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one item and returns at the edge where it is taken. When the gap
  // is zero the valid stays high and only the payload moves on.
  task automatic send_item(input logic m, input logic [KeyW-1:0] k,
                           input logic [DataW-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Lets every outstanding lookup come back and the last put finish, so the
  // block is idle before the capacity changes or the run ends.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_writes++;
  endtask

  // Result side: the stall toggles with random hold times, mostly short
  // stalls and occasionally a long one; quiet phases never stall.
  initial begin
    out_stall <= 1'b0;
    stall_hold = 0;
    forever begin
      @(posedge clk);
      if (stall_hold != 0) begin
        stall_hold--;
      end else if (quiet_phase || out_stall) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(0, 25);
      end else begin
        out_stall <= 1'b1;
        stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
      end
    end
  end

  initial begin
    int cap_now;
    int window;
    logic [KeyW-1:0] k;
    logic m;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    mode <= MODE_GET;
    key <= '0;
    value <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    quiet_phase = 1'b0;
    requests_sent = 0;
    capacity_writes = 0;

    // The pool holds the key extremes plus random keys; reusing it is what
    // makes hits, updates and evictions common in the random part.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity: a lookup in the empty store, the
    // key and value extremes, a hit, a miss, and an update of a present key.
    send_item(MODE_GET, '0, '1);
    send_item(MODE_PUT, '0, '1);
    send_item(MODE_PUT, '1, '0);
    send_item(MODE_PUT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_item(MODE_GET, '0, '0);
    send_item(MODE_GET, '1, '1);
    send_item(MODE_GET, 32'h1234_5678, '0);
    send_item(MODE_PUT, '0, 32'h0000_0001);
    send_item(MODE_GET, '0, '0);
    send_item(MODE_GET, 32'hA5A5_A5A5, '0);

    // Capacity zero acts as one. The store holds three entries, so the first
    // new key trims it down in a single step, and the next one evicts that.
    drain();
    write_capacity('0);
    send_item(MODE_PUT, 32'h1357_9BDF, 32'hDEAD_0001);
    send_item(MODE_PUT, 32'h2468_ACE0, 32'hDEAD_0002);
    send_item(MODE_GET, 32'h1357_9BDF, '0);
    send_item(MODE_GET, 32'h2468_ACE0, '0);

    // A capacity above the slot count acts as the full store.
    drain();
    write_capacity('1);
    send_item(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(MODE_GET, 32'h2468_ACE0, '0);
    send_item(MODE_GET, 32'h8000_0000, '0);

    // Random part: each phase picks a capacity, then draws keys mostly from a
    // window of the pool slightly larger than that capacity. The capacity
    // often drops below the current fill between phases.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == 0) cap_now = ENTRIES;
      else if (phase == 1) cap_now = 1;
      else if ($urandom_range(0, 3) == 0) cap_now = $urandom_range(0, 31);
      else cap_now = $urandom_range(0, ENTRIES);
      write_capacity(CapW'(cap_now));
      if (cap_now < 1) cap_now = 1;
      if (cap_now > ENTRIES) cap_now = ENTRIES;
      window = cap_now + $urandom_range(1, 6);
      if (window > POOL_SIZE) window = POOL_SIZE;
      quiet_phase = (phase % 4 == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, window - 1)];
        else k = $urandom();
        m = $urandom_range(0, 1) ? MODE_PUT : MODE_GET;
        send_item(m, k, $urandom());
      end
    end
    quiet_phase = 1'b0;

    drain();
    $display("Run covered %0d requests over %0d capacity settings.",
             requests_sent, capacity_writes + 1);
    $display("Checked %0d lookups, %0d of them hits.", lookups, hits);
    if (mismatches == 0 && pending == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("lru_key_value_cache: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_kv_mem.sv
hw/rtl/lkv_rank.sv
hw/rtl/lru_key_value_cache.sv
verif/lru_cache_checker.sv
verif/tb_lru_key_value_cache.sv
